### hw/rtl/dmsl_pkg.sv
// Shared types, constants and arithmetic helpers for the dual motor slew limiter.
package dmsl_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int GAIN_FRAC  = 8;
  localparam int LEVEL_W    = 16;
  localparam int STEP_W     = 12;
  localparam int OFFSET_W   = 14;
  localparam int GAIN_W     = 10;
  localparam int ANGLE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Magnitude of a level-wide target, and the serial divide widths.
  localparam int MAG_W   = LEVEL_W + 1;
  localparam int DVD_W   = STEP_W + LEVEL_W - 1;
  localparam int REM_W   = MAG_W + 1;
  localparam int CNT_W   = $clog2(DVD_W);
  // Scaled step never exceeds step * ONE_Q.
  localparam int ADD_W   = STEP_W + FRAC_BITS + 1;
  localparam int SUM_W   = ADD_W + 2;
  localparam int LDIFF_W = LEVEL_W + 1;
  localparam int RPROD_W = LEVEL_W + GAIN_W + 1;
  localparam int RX_W    = RPROD_W - FRAC_BITS - GAIN_FRAC;

  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int LEVEL_HI_RAW = 128 * ONE_Q - 1;
  localparam int LEVEL_LO_RAW = -128 * ONE_Q;
  localparam int LEVEL_HI     = (LEVEL_HI_RAW > 32767) ? 32767 : LEVEL_HI_RAW;
  localparam int LEVEL_LO     = (LEVEL_LO_RAW < -32768) ? -32768 : LEVEL_LO_RAW;

  localparam logic [STEP_W-1:0]   RISE_STEP_RST   = STEP_W'(512);
  localparam logic [STEP_W-1:0]   FALL_STEP_RST   = STEP_W'(256);
  localparam logic [OFFSET_W-1:0] LEFT_OFFSET_RST = OFFSET_W'(1280);
  localparam logic [GAIN_W-1:0]   RIGHT_GAIN_RST  = GAIN_W'(307);

  // Servo map: angle = (x + 127) * 180 / 254 = v * 90 / 127, with v = x + 127.
  localparam int MAP_BIAS   = 127;
  localparam int MAP_SPAN   = 254;
  localparam int ANGLE_MAX  = 180;
  localparam int RECIP_SH   = 22;
  // ceil(2^22 / 127) * 90, exact for v * 90 below 2^15.
  localparam logic [21:0] RECIP_MUL = 22'd2972430;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_STEP   = 2'd0,
    REG_FALL_STEP   = 2'd1,
    REG_LEFT_OFFSET = 2'd2,
    REG_RIGHT_GAIN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      kill;
    logic signed [LEVEL_W-1:0] left_target;
    logic signed [LEVEL_W-1:0] right_target;
  } req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        left_angle;
    logic [ANGLE_W-1:0]        right_angle;
    logic signed [LEVEL_W-1:0] left_now;
    logic signed [LEVEL_W-1:0] right_now;
  } rsp_t;

  // Move a level one step toward its target, then saturate.
  function automatic logic signed [LEVEL_W-1:0] step_level(
    input logic signed [LEVEL_W-1:0] level,
    input logic signed [LEVEL_W-1:0] target,
    input logic [ADD_W-1:0]          add
  );
    logic signed [SUM_W-1:0] lv;
    logic signed [SUM_W-1:0] ad;
    logic signed [SUM_W-1:0] sum;
    lv = SUM_W'(level);
    ad = signed'({2'b00, add});
    if (level > target) begin
      sum = lv - ad;
    end else if (level < target) begin
      sum = lv + ad;
    end else begin
      sum = lv;
    end
    if (sum > SUM_W'(LEVEL_HI)) begin
      sum = SUM_W'(LEVEL_HI);
    end
    if (sum < SUM_W'(LEVEL_LO)) begin
      sum = SUM_W'(LEVEL_LO);
    end
    return sum[LEVEL_W-1:0];
  endfunction

  // Arithmetic shift right that rounds toward zero.
  function automatic logic signed [RPROD_W-1:0] trunc_shift(
    input logic signed [RPROD_W-1:0] x,
    input int                        k
  );
    logic signed [RPROD_W-1:0] bias;
    bias = (RPROD_W'(1) <<< k) - RPROD_W'(1);
    if (x < 0) begin
      return (x + bias) >>> k;
    end
    return x >>> k;
  endfunction

  function automatic logic [ANGLE_W-1:0] to_angle(input logic signed [RPROD_W-1:0] x);
    logic signed [RPROD_W:0] v;
    logic [29:0]             p;
    v = (RPROD_W+1)'(x) + (RPROD_W+1)'(MAP_BIAS);
    p = {22'd0, v[7:0]} * {8'd0, RECIP_MUL};
    if (v <= 0) begin
      return '0;
    end else if (v >= (RPROD_W+1)'(MAP_SPAN)) begin
      return ANGLE_W'(ANGLE_MAX);
    end
    return p[RECIP_SH +: ANGLE_W];
  endfunction

endpackage

### hw/rtl/dual_motor_slew_limiter_core.sv
// Dual motor slew limiter: slew step, bit-serial ratio divide, trim and servo mapping.
// A request passes through S_PREP, S_MUL, S_DIV, S_UPD and S_MAP1 to S_MAP3 before its result is valid.
// Flow: a new request is taken only in S_IDLE, one at a time; the next request
//   is taken while a finished result still waits in the output register, but a stalled output holds the core in S_HOLD.
// The 27-step restoring divider for step * lesser / big takes most of each request's time.
// Reset (rst, synchronous): levels cleared, registers back to defaults, no result pending.
module dual_motor_slew_limiter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  dmsl_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output dmsl_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dmsl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_UPD  = 9'b000010000,
    S_MAP1 = 9'b000100000,
    S_MAP2 = 9'b001000000,
    S_MAP3 = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [STEP_W-1:0]   rise_step;
  logic [STEP_W-1:0]   fall_step;
  logic [OFFSET_W-1:0] left_offset;
  logic [GAIN_W-1:0]   right_gain;

  logic signed [LEVEL_W-1:0] left_level;
  logic signed [LEVEL_W-1:0] right_level;
  logic signed [LEVEL_W-1:0] lt;
  logic signed [LEVEL_W-1:0] rt;

  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  big;
  logic [MAG_W-1:0]  lesser;
  logic              scale_left;
  logic              scale_right;

  logic [DVD_W-1:0] dvd;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  logic signed [LDIFF_W-1:0] ldiff;
  logic signed [RPROD_W-1:0] rprod;
  logic signed [LDIFF_W-1:0] lx;
  logic signed [RX_W-1:0]    rx;

  logic             req_take;
  logic             rsp_load;
  logic [MAG_W-1:0] lm;
  logic [MAG_W-1:0] rm;
  logic [MAG_W-1:0] big_raw;
  logic [MAG_W-1:0] lesser_raw;
  logic [REM_W:0]   trial;
  logic [ADD_W-1:0] quot;
  logic [ADD_W-1:0] ladd;
  logic [ADD_W-1:0] radd;
  logic [STEP_W+MAG_W-1:0] prod;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_load  = (state == S_MAP3) && (!rsp_valid || !rsp_stall);

  always_comb begin
    lm         = lt[LEVEL_W-1] ? MAG_W'(-MAG_W'(lt)) : MAG_W'(lt);
    rm         = rt[LEVEL_W-1] ? MAG_W'(-MAG_W'(rt)) : MAG_W'(rt);
    big_raw    = (lm > rm) ? lm : rm;
    lesser_raw = (lm < rm) ? lm : rm;
    prod       = {{MAG_W{1'b0}}, step} * {{STEP_W{1'b0}}, lesser};
    trial      = {1'b0, rem[REM_W-2:0], dvd[DVD_W-1]} - {2'b00, big};
    quot       = dvd[ADD_W-1:0];
    ladd       = scale_left  ? quot : ADD_W'(step);
    radd       = scale_right ? quot : ADD_W'(step);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_take) state_next = S_PREP;
      S_PREP: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (cnt == '0) state_next = S_UPD;
      S_UPD:  state_next = S_MAP1;
      S_MAP1: state_next = S_MAP2;
      S_MAP2: state_next = S_MAP3;
      S_MAP3: state_next = rsp_load ? S_IDLE : S_HOLD;
      S_HOLD: state_next = S_MAP3;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rise_step   <= RISE_STEP_RST;
      fall_step   <= FALL_STEP_RST;
      left_offset <= LEFT_OFFSET_RST;
      right_gain  <= RIGHT_GAIN_RST;
      left_level  <= '0;
      right_level <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_RISE_STEP:   rise_step   <= cfg_data[STEP_W-1:0];
          REG_FALL_STEP:   fall_step   <= cfg_data[STEP_W-1:0];
          REG_LEFT_OFFSET: left_offset <= cfg_data[OFFSET_W-1:0];
          REG_RIGHT_GAIN:  right_gain  <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (state == S_UPD) begin
        left_level  <= step_level(left_level, lt, ladd);
        right_level <= step_level(right_level, rt, radd);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lt <= req.kill ? '0 : req.left_target;
        rt <= req.kill ? '0 : req.right_target;
      end
      S_PREP: begin
        step        <= (lt < left_level && rt < right_level) ? fall_step : rise_step;
        big         <= (big_raw == '0) ? MAG_W'(ONE_Q) : big_raw;
        lesser      <= (lesser_raw == '0) ? MAG_W'(ONE_Q) : lesser_raw;
        scale_left  <= lm < rm;
        scale_right <= lm > rm;
      end
      S_MUL: begin
        dvd <= prod[DVD_W-1:0];
        rem <= '0;
        cnt <= CNT_W'(DVD_W - 1);
      end
      S_DIV: begin
        // Restoring step: shift in one dividend bit, keep the trial if it fits.
        if (!trial[REM_W]) begin
          rem <= trial[REM_W-1:0];
          dvd <= {dvd[DVD_W-2:0], 1'b1};
        end else begin
          rem <= {rem[REM_W-2:0], dvd[DVD_W-1]};
          dvd <= {dvd[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
      end
      S_MAP1: begin
        ldiff <= LDIFF_W'(left_level) - signed'({{(LDIFF_W-OFFSET_W){1'b0}}, left_offset});
        rprod <= RPROD_W'(right_level) * signed'({{(RPROD_W-GAIN_W){1'b0}}, right_gain});
      end
      S_MAP2: begin
        lx <= LDIFF_W'(trunc_shift(RPROD_W'(ldiff), FRAC_BITS));
        rx <= RX_W'(trunc_shift(rprod, FRAC_BITS + GAIN_FRAC));
      end
      S_MAP3: begin
        if (rsp_load) begin
          rsp.left_angle  <= to_angle(RPROD_W'(lx));
          rsp.right_angle <= to_angle(RPROD_W'(rx));
          rsp.left_now    <= left_level;
          rsp.right_now   <= right_level;
        end
      end
      default: ;
    endcase
  end

  // The zero guard must hold before the divider starts.
  assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> (big != '0 && lesser != '0))
    else $error("divider started with zero operand");

  // The scaled step must fit the adder width.
  assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> dvd[DVD_W-1:ADD_W] == '0)
    else $error("scaled step overflows adder width");

  // A result appears only from the mapping stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_MAP3)
    else $error("result raised outside mapping stage");

endmodule
